// ----- src/sfr_pkg.sv -----
// Shared types, constants and the CRC-8 step function for the frame receiver.
// No dependencies; every other file imports this package.
package sfr_pkg;

  // Largest payload the buffer holds
  localparam int MAX_PAYLOAD = 32;
  localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 6;

  // Depth of the frame descriptor queue between front and back
  localparam int QDEPTH = 2;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [2:0] REG_LEN_LIMIT   = 3'd2;
  localparam logic [2:0] REG_CRC_POLY    = 3'd3;
  localparam logic [2:0] REG_CRC_START   = 3'd4;

  // Configuration seen by the front end
  typedef struct packed {
    logic [7:0]       sync_first;
    logic [7:0]       sync_second;
    logic [LEN_W-1:0] length_limit;
    logic [7:0]       crc_polynomial;
    logic [7:0]       crc_start;
  } cfg_t;

  // One completed frame, handed from front to back
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
  } desc_t;

  // Payload buffer write
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // CRC-8, msb first, no reflection
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/sfr_queue.sv -----
// Small FIFO of frame descriptors between the front and back ends.
// Depends on sfr_pkg (desc_t, QDEPTH).
module sfr_queue import sfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output desc_t pop_data,
  output logic  empty
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  desc_t            entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/sfr_front.sv -----
// Front end: sync hunt, length/command parse, running CRC, payload buffer writes.
// Depends on sfr_pkg; pushes completed frames into the descriptor queue.
module sfr_front import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       back_busy,
  input  logic       q_full,
  input  logic       q_empty,
  output logic       q_push,
  output desc_t      q_data,
  output mem_wr_t    wr
);

  localparam logic [2:0] PH_SYNC_A  = 3'd0;
  localparam logic [2:0] PH_SYNC_B  = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_CMD     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;

  logic [2:0]       phase, phase_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [7:0]       frame_command, frame_command_next;
  logic [LEN_W-1:0] bytes_collected, bytes_collected_next;
  logic [7:0]       running_crc, running_crc_next;

  logic             accept;
  logic [7:0]       limit;
  logic [7:0]       crc_in;
  logic [7:0]       crc_out;
  logic [LEN_W-1:0] count_inc;

  // payload must wait for the buffer to drain; CRC byte needs queue space
  assign in_ready = !((phase == PH_PAYLOAD) && (back_busy || !q_empty)) &&
                    !((phase == PH_CRC) && q_full);
  assign accept   = in_valid && in_ready;

  // effective length limit
  assign limit = (cfg.length_limit > LEN_W'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                         : 8'(cfg.length_limit);

  // one CRC step per byte; seeded at the length byte
  assign crc_in    = (phase == PH_LEN) ? cfg.crc_start : running_crc;
  assign crc_out   = crc8_update(crc_in, rx_byte, cfg.crc_polynomial);
  assign count_inc = bytes_collected + 1'b1;

  // parse sequencer
  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    frame_command_next   = frame_command;
    bytes_collected_next = bytes_collected;
    running_crc_next     = running_crc;
    q_push               = 1'b0;
    q_data.kind          = (rx_byte == running_crc) ? KIND_HEADER : KIND_ERROR;
    q_data.command       = frame_command;
    q_data.length        = frame_length;
    wr.en                = 1'b0;
    wr.addr              = bytes_collected[ADDR_W-1:0];
    wr.data              = rx_byte;
    if (accept) begin
      case (phase)
        PH_SYNC_A: begin
          if (rx_byte == cfg.sync_first) begin
            phase_next = PH_SYNC_B;
          end
        end
        PH_SYNC_B: begin
          phase_next = (rx_byte == cfg.sync_second) ? PH_LEN : PH_SYNC_A;
        end
        PH_LEN: begin
          if (rx_byte > limit) begin
            phase_next           = PH_SYNC_A;
            frame_length_next    = '0;
            frame_command_next   = '0;
            bytes_collected_next = '0;
            running_crc_next     = '0;
          end else begin
            frame_length_next    = rx_byte[LEN_W-1:0];
            bytes_collected_next = '0;
            running_crc_next     = crc_out;
            phase_next           = PH_CMD;
          end
        end
        PH_CMD: begin
          frame_command_next = rx_byte;
          running_crc_next   = crc_out;
          phase_next         = (frame_length != '0) ? PH_PAYLOAD : PH_CRC;
        end
        PH_PAYLOAD: begin
          wr.en                = 1'b1;
          bytes_collected_next = count_inc;
          running_crc_next     = crc_out;
          if (count_inc >= frame_length) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          q_push               = 1'b1;
          phase_next           = PH_SYNC_A;
          frame_length_next    = '0;
          frame_command_next   = '0;
          bytes_collected_next = '0;
          running_crc_next     = '0;
        end
        default: begin
          phase_next           = PH_SYNC_A;
          frame_length_next    = '0;
          frame_command_next   = '0;
          bytes_collected_next = '0;
          running_crc_next     = '0;
        end
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC_A;
      frame_length    <= '0;
      frame_command   <= '0;
      bytes_collected <= '0;
      running_crc     <= '0;
    end else begin
      phase           <= phase_next;
      frame_length    <= frame_length_next;
      frame_command   <= frame_command_next;
      bytes_collected <= bytes_collected_next;
      running_crc     <= running_crc_next;
    end
  end

endmodule

// ----- src/sfr_back.sv -----
// Back end: payload buffer, header/error emission and payload replay.
// Depends on sfr_pkg; pops descriptors from the queue, drives the result register.
module sfr_back import sfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  desc_t            q_data,
  output logic             q_pop,
  input  mem_wr_t          wr,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       command,
  output logic [LEN_W-1:0] length,
  output logic [7:0]       data,
  output logic             last
);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_PAY  = 1'b1;

  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       mem_q;
  logic             state;
  logic [LEN_W-1:0] idx;
  logic             q_ok;
  logic             out_free;
  logic             final_byte;
  logic             load_pay;

  assign out_free   = !out_valid || out_ready;
  assign q_pop      = (state == B_IDLE) && !q_empty && out_free;
  assign busy       = (state != B_IDLE);
  assign final_byte = ((idx + 1'b1) == length);
  assign load_pay   = (state == B_PAY) && q_ok && out_free;

  // payload buffer, registered read at the replay index
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[idx[ADDR_W-1:0]];
  end

  // replay sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      q_ok      <= 1'b0;
    end else begin
      if (q_pop || load_pay) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            kind      <= q_data.kind;
            command   <= q_data.command;
            length    <= q_data.length;
            data      <= 8'd0;
            last      <= (q_data.kind != KIND_HEADER) || (q_data.length == '0);
            idx       <= '0;
            q_ok      <= 1'b0;
            if ((q_data.kind == KIND_HEADER) && (q_data.length != '0)) begin
              state <= B_PAY;
            end
          end
        end
        B_PAY: begin
          if (load_pay) begin
            kind      <= KIND_DATA;
            data      <= mem_q;
            last      <= final_byte;
            idx       <= idx + 1'b1;
            q_ok      <= 1'b0;
            if (final_byte) begin
              state <= B_IDLE;
            end
          end else begin
            q_ok <= 1'b1;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/sync_length_crc_frame_receiver.sv -----
// Frame receiver for a byte-serial link. One received byte is taken per request
// and is normally accepted in the cycle it is offered. The front end hunts for two
// sync bytes, reads length, command, payload and CRC-8, and writes the payload into
// a 32-byte buffer; completed frames wait in a two-entry descriptor queue. The back
// end emits a header result in the cycle after it pops a good frame, then replays the
// payload byte by byte (a buffer read, then a result load once the output is free), or
// emits one error result on a CRC mismatch. Payload bytes of a following frame are
// held off until the previous replay has finished and the queue is empty, and the CRC
// byte waits while the queue is full; sync, length and command bytes never wait.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
module sync_length_crc_frame_receiver import sfr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // byte input
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  // results
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       command,
  output logic [LEN_W-1:0] length,
  output logic [7:0]       data,
  output logic             last
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       reg_wr;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  desc_t      q_in;
  desc_t      q_out;
  mem_wr_t    wr;
  logic       back_busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first     <= 8'hAA;
      cfg.sync_second    <= 8'h55;
      cfg.length_limit   <= LEN_W'(32);
      cfg.crc_polynomial <= 8'h31;
      cfg.crc_start      <= 8'hFF;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_SYNC_FIRST:  cfg.sync_first     <= pwdata[7:0];
        REG_SYNC_SECOND: cfg.sync_second    <= pwdata[7:0];
        REG_LEN_LIMIT:   cfg.length_limit   <= pwdata[LEN_W-1:0];
        REG_CRC_POLY:    cfg.crc_polynomial <= pwdata[7:0];
        REG_CRC_START:   cfg.crc_start      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg.sync_second};
      REG_LEN_LIMIT:   prdata = {{(32 - LEN_W){1'b0}}, cfg.length_limit};
      REG_CRC_POLY:    prdata = {24'd0, cfg.crc_polynomial};
      REG_CRC_START:   prdata = {24'd0, cfg.crc_start};
      default:         prdata = 32'd0;
    endcase
  end

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .back_busy (back_busy),
    .q_full    (q_full),
    .q_empty   (q_empty),
    .q_push    (q_push),
    .q_data    (q_in),
    .wr        (wr)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .wr        (wr),
    .busy      (back_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .command   (command),
    .length    (length),
    .data      (data),
    .last      (last)
  );

  // buffer is only written when no replay can still read it
  a_wr_when_drained: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (!back_busy && q_empty))
    else $error("payload buffer written while a replay is pending");

  // front end never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("descriptor queue overflow");

  // error result is always a single closing result with no data
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_ERROR)) |-> (last && (data == 8'd0)))
    else $error("malformed error result");

  // payload results only belong to frames with a payload
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DATA)) |-> (length != '0))
    else $error("payload result for an empty frame");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for sync_length_crc_frame_receiver: drives received bytes and
// register writes, predicts header, payload and CRC-error results, and checks each one.
// Depends on sfr_pkg and the receiver RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_GAP     = 12;       // cycles allowed for in-flight work before a write
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int RANDOM_BYTES = 60;
  localparam int MAX_REPORTS  = 10;
  localparam int RUN_LIMIT    = 400000;   // cycles before the watchdog fires

  // Parser position of the predictor
  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_LEN, GET_CMD, GET_PAYLOAD, GET_CRC
  } rx_phase_e;

  // One result as seen on the output ports
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
    logic [7:0]       data;
    logic             last;
  } frame_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             psel, penable, pwrite;
  logic [4:0]       paddr;
  logic [31:0]      pwdata, prdata;
  logic             pready;
  logic             in_valid, in_ready;
  logic [7:0]       rx_byte;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       kind;
  logic [7:0]       command;
  logic [LEN_W-1:0] length;
  logic [7:0]       data;
  logic             last;

  sync_length_crc_frame_receiver uut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .rx_byte,
    .out_valid, .out_ready, .kind, .command, .length, .data, .last
  );

  always #(CLK_HALF) clk = ~clk;

  // Predictor copy of the registers
  logic [7:0]       cfg_sync_first, cfg_sync_second, cfg_poly, cfg_crc_start;
  logic [LEN_W-1:0] cfg_len_limit;

  // Predictor copy of the frame state
  rx_phase_e        rx_phase;
  logic [LEN_W-1:0] frame_len;
  logic [7:0]       frame_cmd;
  int               collected;
  logic [7:0]       frame_crc;
  logic [7:0]       payload_bytes [MAX_PAYLOAD];

  frame_result_t    pending_results [$];

  int mismatch_count = 0;
  int bytes_sent = 0;
  int reg_writes = 0;
  int headers_seen = 0, payload_seen = 0, crc_errors_seen = 0;

  // Sender pacing
  bit pace_on = 1'b1;
  int burst_left = 0;

  // Receiver hold-off request, toggled by the tests
  logic hold_trigger = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  logic [7:0] stall_step = '0;

  // CRC-8 msb first, no reflection
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    logic       top;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      top = c[7];
      c = c << 1;
      if (top) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

  function automatic int usable_limit();
    return (cfg_len_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(cfg_len_limit);
  endfunction

  function automatic void clear_frame_state();
    rx_phase  = HUNT_FIRST;
    frame_len = '0;
    frame_cmd = '0;
    collected = 0;
    frame_crc = '0;
  endfunction

  function automatic void report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s", $realtime, what);
    end
  endfunction

  function automatic frame_result_t make_result(input logic [1:0] k, input logic [7:0] d,
                                                input logic fin);
    frame_result_t r;
    r.kind    = k;
    r.command = frame_cmd;
    r.length  = frame_len;
    r.data    = d;
    r.last    = fin;
    return r;
  endfunction

  // Advance the predictor by one accepted byte and queue the results it causes
  function automatic void track_frame_byte(input logic [7:0] b);
    case (rx_phase)
      HUNT_FIRST: begin
        if (b == cfg_sync_first) rx_phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        rx_phase = (b == cfg_sync_second) ? GET_LEN : HUNT_FIRST;
      end
      GET_LEN: begin
        if (int'(b) > usable_limit()) begin
          clear_frame_state();
        end else begin
          frame_len = b[LEN_W-1:0];
          collected = 0;
          frame_crc = crc8_next(cfg_crc_start, b, cfg_poly);
          rx_phase  = GET_CMD;
        end
      end
      GET_CMD: begin
        frame_cmd = b;
        frame_crc = crc8_next(frame_crc, b, cfg_poly);
        rx_phase  = (frame_len > 0) ? GET_PAYLOAD : GET_CRC;
      end
      GET_PAYLOAD: begin
        if (collected < MAX_PAYLOAD) begin
          payload_bytes[collected] = b;
          collected++;
        end
        frame_crc = crc8_next(frame_crc, b, cfg_poly);
        if (collected >= frame_len || collected >= MAX_PAYLOAD) rx_phase = GET_CRC;
      end
      GET_CRC: begin
        if (b == frame_crc) begin
          pending_results.push_back(make_result(KIND_HEADER, 8'h00, frame_len == 0));
          for (int i = 0; i < frame_len && i < MAX_PAYLOAD; i++) begin
            pending_results.push_back(make_result(KIND_DATA, payload_bytes[i],
                                                  i + 1 == frame_len));
          end
        end else begin
          pending_results.push_back(make_result(KIND_ERROR, 8'h00, 1'b1));
        end
        clear_frame_state();
      end
      default: clear_frame_state();
    endcase
  endfunction

  // Send one byte request, with burst/gap pacing, and predict on acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (pace_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        repeat (gap) @(negedge clk) in_valid <= 1'b0;
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    track_frame_byte(b);
    bytes_sent++;
  endtask

  // Whole frame under the current settings; fill < 0 gives random payload
  task automatic drive_frame(input int len, input logic [7:0] cmd, input bit corrupt,
                             input int fill);
    logic [7:0] crc, b;
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    crc = crc8_next(cfg_crc_start, 8'(len), cfg_poly);
    send_byte(8'(len));
    crc = crc8_next(crc, cmd, cfg_poly);
    send_byte(cmd);
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      crc = crc8_next(crc, b, cfg_poly);
      send_byte(b);
    end
    if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(crc);
  endtask

  // Sync pair followed by a length above the usable limit
  task automatic send_oversized(input int len);
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    send_byte(8'(len));
  endtask

  // Stop offering bytes, wait until every expected result has come out, plus some margin
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Register write: setup cycle then access cycle; junk in the upper data bits
  task automatic reg_write(input logic [2:0] idx, input logic [7:0] value);
    logic [31:0] junk;
    junk = $urandom();
    @(negedge clk);
    in_valid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= {idx, 2'b00};
    pwdata   <= {junk[31:8], value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SYNC_FIRST:  cfg_sync_first  = value;
      REG_SYNC_SECOND: cfg_sync_second = value;
      REG_LEN_LIMIT:   cfg_len_limit   = value[LEN_W-1:0];
      REG_CRC_POLY:    cfg_poly        = value;
      REG_CRC_START:   cfg_crc_start   = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_readback(input logic [2:0] idx, input logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      report_mismatch($sformatf("register %0d read: expected %h got %h", idx, want, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] s1, input logic [7:0] s2, input logic [7:0] lim,
                           input logic [7:0] poly, input logic [7:0] start);
    wait_idle();
    reg_write(REG_SYNC_FIRST, s1);
    reg_write(REG_SYNC_SECOND, s2);
    reg_write(REG_LEN_LIMIT, lim);
    reg_write(REG_CRC_POLY, poly);
    reg_write(REG_CRC_START, start);
  endtask

  // Edge frames under reset settings: empty, single byte, bad CRC, oversize, resync
  task automatic test_directed_cases();
    drive_frame(0, 8'h00, 1'b0, 0);
    drive_frame(1, 8'hFF, 1'b0, 8'hFF);
    drive_frame(1, 8'h00, 1'b0, 8'h00);
    drive_frame(3, 8'h5A, 1'b1, -1);
    send_oversized(MAX_PAYLOAD + 1);
    send_oversized(255);
    // second sync mismatching with a byte equal to the first sync
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    drive_frame(0, 8'hA5, 1'b0, 0);
  endtask

  // Several register settings, extremes included, with a readback of each register
  task automatic test_register_settings();
    // zero length limit: only empty frames pass
    write_all(8'h00, 8'hFF, 8'h00, 8'h07, 8'h00);
    reg_readback(REG_SYNC_FIRST, 32'h00);
    reg_readback(REG_SYNC_SECOND, 32'hFF);
    reg_readback(REG_LEN_LIMIT, 32'h00);
    reg_readback(REG_CRC_POLY, 32'h07);
    reg_readback(REG_CRC_START, 32'h00);
    drive_frame(0, 8'h3C, 1'b0, 0);
    drive_frame(0, 8'hC3, 1'b1, 0);
    send_oversized(1);
    drive_frame(0, 8'hFF, 1'b0, 0);
    // limit above the buffer size acts as the buffer size
    write_all(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    reg_readback(REG_LEN_LIMIT, 32'h3F);
    drive_frame(MAX_PAYLOAD, 8'h81, 1'b0, -1);
    send_oversized(MAX_PAYLOAD + 1);
    drive_frame(MAX_PAYLOAD, 8'h18, 1'b1, -1);
    // zero polynomial, small limit
    write_all(8'h7E, 8'h81, 8'h01, 8'h00, 8'h80);
    drive_frame(1, 8'h01, 1'b0, -1);
    send_oversized(2);
    drive_frame(0, 8'h02, 1'b1, 0);
  endtask

  // Register changes inside a frame take effect from the next byte
  task automatic test_midframe_config();
    logic [7:0] crc;
    write_all(8'hAA, 8'h55, 8'd32, 8'h31, 8'hFF);
    send_byte(cfg_sync_first);
    send_byte(cfg_sync_second);
    wait_idle();
    reg_write(REG_CRC_START, 8'h3C);
    send_byte(8'd2);
    wait_idle();
    reg_write(REG_CRC_START, 8'hC3);   // too late for this frame
    reg_write(REG_CRC_POLY, 8'h1D);    // applies from the command byte
    crc = crc8_next(8'h3C, 8'd2, 8'h31);
    crc = crc8_next(crc, 8'h42, 8'h1D);
    crc = crc8_next(crc, 8'h00, 8'h1D);
    crc = crc8_next(crc, 8'hFF, 8'h1D);
    send_byte(8'h42);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(crc);
    drive_frame(2, 8'h43, 1'b0, -1);
  endtask

  // Long receiver hold-off with back-to-back frames so the input stalls
  task automatic test_output_backpressure();
    wait_idle();
    hold_trigger = ~hold_trigger;
    pace_on = 1'b0;
    for (int i = 0; i < 4; i++) begin
      drive_frame(8, 8'(i), 1'b0, -1);
    end
    pace_on = 1'b1;
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise
  task automatic test_random_traffic();
    int start_count, pick, eff, len;
    logic [7:0] b;
    write_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(4, 40)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      eff  = usable_limit();
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? eff : $urandom_range(0, (eff < 6) ? eff : 6);
      if (pick < 70) begin
        drive_frame(len, 8'($urandom_range(0, 255)), 1'b0, -1);
      end else if (pick < 80) begin
        drive_frame(len, 8'($urandom_range(0, 255)), 1'b1, -1);
      end else if (pick < 87) begin
        send_oversized($urandom_range(eff + 1, 255));
      end else if (pick < 93) begin
        send_byte(cfg_sync_first);
        do b = 8'($urandom_range(0, 255)); while (b == cfg_sync_second);
        send_byte(b);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver ready: changing stall patterns, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_step <= stall_step + 1'b1;
      case (stall_step[7:6])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    frame_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{kind, command, length, data, last};
      case (kind)
        KIND_HEADER: headers_seen++;
        KIND_DATA:   payload_seen++;
        default:     crc_errors_seen++;
      endcase
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d cmd=%h len=%0d data=%h last=%b",
                                  kind, command, length, data, last));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.command !== want.command ||
            got.length !== want.length || got.data !== want.data ||
            got.last !== want.last) begin
          report_mismatch($sformatf(
            {"expected kind=%0d cmd=%h len=%0d data=%h last=%b, ",
             "got kind=%0d cmd=%h len=%0d data=%h last=%b"},
            want.kind, want.command, want.length, want.data, want.last,
            got.kind, got.command, got.length, got.data, got.last));
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(2 * CLK_HALF * RUN_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // Test sequence
  initial begin
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_sync_first  = 8'hAA;
    cfg_sync_second = 8'h55;
    cfg_len_limit   = LEN_W'(32);
    cfg_poly        = 8'h31;
    cfg_crc_start   = 8'hFF;
    clear_frame_state();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed_cases();
    test_register_settings();
    test_midframe_config();
    test_output_backpressure();
    test_random_traffic();

    // drain, then let the pipeline settle
    @(negedge clk) in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * IDLE_GAP) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never came out",
                                pending_results.size()));
    end

    $display("Run covered %0d input bytes and %0d register writes, %0d-cycle output hold-off.",
             bytes_sent, reg_writes, HOLD_CYCLES);
    $display("Results checked: %0d headers, %0d payload bytes, %0d CRC errors; %0d mismatches.",
             headers_seen, payload_seen, crc_errors_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/sfr_pkg.sv
src/sfr_queue.sv
src/sfr_front.sv
src/sfr_back.sv
src/sync_length_crc_frame_receiver.sv
tb/tb_top.sv
